FILE: hw/rtl/hashed_key_sorted_table_assert.svh
// Assertion macros for the RTL of the keyed sorted table.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef HASHED_KEY_SORTED_TABLE_ASSERT_SVH
`define HASHED_KEY_SORTED_TABLE_ASSERT_SVH
`ifndef SYNTH
`define HKST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define HKST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HKST_ASSERT_SAME(lbl, ante, cons, msg)
`define HKST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/hkst_pkg.sv
`timescale 1ns / 1ps
package hkst_pkg;

  localparam int TABLE_DEPTH_DEF     = 64;
  localparam int HANDLES_PER_KEY_DEF = 8;

  localparam logic [63:0] HASH_SEED = 64'd5381;
  localparam logic [30:0] HASH_MOD  = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_SPARE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TBL_FULL  = 2'd2,
    ST_LIST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] data_handle;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] handle_out;
    logic [3:0]  item_count;
    logic        last_result;
  } out_t;

endpackage

FILE: hw/rtl/hkst_ram.sv
`timescale 1ns / 1ps
module hkst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write one word, register one read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/hashed_key_sorted_table.sv
`timescale 1ns / 1ps
// Keyed handle table. Key bytes stream in one per transaction and fold into a
// djb2 hash; the byte flagged key_last reduces the hash modulo 2^31-1 by
// folding and runs the request against a table kept sorted by hash in an
// entry RAM, with handles in a second RAM of HANDLES_PER_KEY slots per entry.
// Both RAMs have one write and one registered read port, so each binary-search
// step reads in S_SEARCH and compares in S_SCMP, each moved entry is read in
// S_SHR and written in S_SHW, each moved handle slot is read in S_HSR and
// written in S_HSW on an insert of a new key or a remove (a whole row of slots
// per entry), and each returned handle is read in S_LURD and sent in S_LUOUT
// on a lookup. While an operation runs in_stall stays high; a result waits in
// the output register without blocking the next key bytes.
module hashed_key_sorted_table
  import hkst_pkg::*;
#(
  parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
  parameter int HANDLES_PER_KEY = HANDLES_PER_KEY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

`include "hashed_key_sorted_table_assert.svh"

  localparam int EAW = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int HCW = $clog2(HANDLES_PER_KEY + 1);
  localparam int HD  = TABLE_DEPTH * HANDLES_PER_KEY;
  localparam int HAW = $clog2(HD);
  localparam int HFW = $clog2(HD + 1);
  localparam int EDW = 31 + HCW;

  localparam logic [CW-1:0]  TD_C  = CW'(TABLE_DEPTH);
  localparam logic [HCW-1:0] HPK_C = HCW'(HANDLES_PER_KEY);
  localparam logic [HFW-1:0] HPK_F = HFW'(HANDLES_PER_KEY);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_FOLD   = 13'b0000000000010,
    S_SEARCH = 13'b0000000000100,
    S_SCMP   = 13'b0000000001000,
    S_CHK    = 13'b0000000010000,
    S_SHR    = 13'b0000000100000,
    S_SHW    = 13'b0000001000000,
    S_HSR    = 13'b0000010000000,
    S_HSW    = 13'b0000100000000,
    S_FIN    = 13'b0001000000000,
    S_LURD   = 13'b0010000000000,
    S_LUOUT  = 13'b0100000000000,
    S_RESP   = 13'b1000000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [63:0]     acc_r, acc_nxt;
  logic [63:0]     fold_r, fold_nxt;
  logic [30:0]     h_r, h_nxt;
  logic [1:0]      req_r, req_nxt;
  logic [31:0]     hdl_r, hdl_nxt;
  logic [CW-1:0]   total_r, total_nxt;
  logic [CW-1:0]   lo_r, lo_nxt;
  logic [CW-1:0]   hi_r, hi_nxt;
  logic [CW-1:0]   mid_r, mid_nxt;
  logic [CW-1:0]   e_r, e_nxt;
  logic [HFW-1:0]  a_r, a_nxt;
  logic [HFW-1:0]  base_r, base_nxt;
  logic [HFW-1:0]  end_r, end_nxt;
  logic [HCW-1:0]  cnt_r, cnt_nxt;
  logic [HCW-1:0]  i_r, i_nxt;
  out_t            res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_data_r, out_data_nxt;

  logic            ent_we, ent_re;
  logic [EAW-1:0]  ent_waddr, ent_raddr;
  logic [EDW-1:0]  ent_wdata, ent_rd;
  logic            hdl_we, hdl_re;
  logic [HAW-1:0]  hdl_waddr, hdl_raddr;
  logic [31:0]     hdl_wdata, hdl_rd;

  logic [30:0]     rd_hash;
  logic [HCW-1:0]  rd_cnt;
  logic            in_acc, slot_free, found;
  logic [63:0]     acc_step;
  logic [CW-1:0]   mid_c, e_up, e_dn;
  logic [HFW-1:0]  base_c, end_c, lu_addr, a_up, a_dn;
  logic [HCW-1:0]  n_c;

  assign rd_hash   = ent_rd[HCW +: 31];
  assign rd_cnt    = ent_rd[HCW-1:0];
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign acc_step  = (acc_r << 5) + acc_r + 64'(in_data.key_byte);
  assign mid_c     = lo_r + ((hi_r - lo_r) >> 1);
  assign e_up      = e_r + CW'(1);
  assign e_dn      = e_r - CW'(1);
  assign base_c    = HFW'(HFW'(lo_r) * HPK_F);
  assign end_c     = HFW'(HFW'(total_r) * HPK_F);
  assign lu_addr   = base_r + HFW'(i_r);
  assign a_up      = a_r + HPK_F;
  assign a_dn      = a_r - HPK_F;
  assign found     = (lo_r < total_r) && (rd_hash == h_r);
  assign n_c       = (rd_cnt > HPK_C) ? HPK_C : rd_cnt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // entry RAM: {hash, handle count}
  hkst_ram #(.WIDTH(EDW), .DEPTH(TABLE_DEPTH)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  // handle RAM: one row of slots per entry
  hkst_ram #(.WIDTH(32), .DEPTH(HD)) u_hdl_ram (
    .clk   (clk),
    .we    (hdl_we),
    .waddr (hdl_waddr),
    .wdata (hdl_wdata),
    .re    (hdl_re),
    .raddr (hdl_raddr),
    .rdata (hdl_rd)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    fold_nxt      = fold_r;
    h_nxt         = h_r;
    req_nxt       = req_r;
    hdl_nxt       = hdl_r;
    total_nxt     = total_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    e_nxt         = e_r;
    a_nxt         = a_r;
    base_nxt      = base_r;
    end_nxt       = end_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ent_we        = 1'b0;
    ent_re        = 1'b0;
    ent_waddr     = lo_r[EAW-1:0];
    ent_raddr     = lo_r[EAW-1:0];
    ent_wdata     = {h_r, HCW'(1)};
    hdl_we        = 1'b0;
    hdl_re        = 1'b0;
    hdl_waddr     = base_r[HAW-1:0];
    hdl_raddr     = a_r[HAW-1:0];
    hdl_wdata     = hdl_r;

    // drop a taken result
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          acc_nxt = acc_step;
          if (in_data.key_last) begin
            fold_nxt  = acc_step;
            acc_nxt   = HASH_SEED;
            req_nxt   = in_data.req_type;
            hdl_nxt   = in_data.data_handle;
            state_nxt = S_FOLD;
          end
        end
      end
      S_FOLD: begin
        // fold 31-bit chunks until the value fits, then map the modulus to zero
        if (fold_r[63:31] == '0) begin
          h_nxt     = (fold_r[30:0] == HASH_MOD) ? '0 : fold_r[30:0];
          lo_nxt    = '0;
          hi_nxt    = total_r;
          state_nxt = S_SEARCH;
        end else begin
          fold_nxt = 64'(fold_r[30:0]) + 64'(fold_r[63:31]);
        end
      end
      S_SEARCH: begin
        ent_re = 1'b1;
        if (lo_r < hi_r) begin
          mid_nxt   = mid_c;
          ent_raddr = mid_c[EAW-1:0];
          state_nxt = S_SCMP;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_SCMP: begin
        if (rd_hash < h_r) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_SEARCH;
      end
      S_CHK: begin
        base_nxt  = base_c;
        end_nxt   = end_c;
        res_nxt   = '{status: ST_OK, handle_out: '0, item_count: '0, last_result: 1'b1};
        state_nxt = S_RESP;
        if (req_r == REQ_INSERT) begin
          if (found) begin
            res_nxt.item_count = 4'(rd_cnt);
            if (rd_cnt >= HPK_C) begin
              res_nxt.status = ST_LIST_FULL;
            end else begin
              ent_we             = 1'b1;
              ent_wdata          = {h_r, rd_cnt + HCW'(1)};
              hdl_we             = 1'b1;
              hdl_waddr          = HAW'(base_c + HFW'(rd_cnt));
              res_nxt.item_count = 4'(rd_cnt + HCW'(1));
            end
          end else if (total_r >= TD_C) begin
            res_nxt.status = ST_TBL_FULL;
          end else if (total_r > lo_r) begin
            e_nxt     = total_r - CW'(1);
            a_nxt     = end_c - HFW'(1);
            state_nxt = S_SHR;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (!found) begin
          res_nxt.status = ST_NOT_FOUND;
        end else if (req_r == REQ_REMOVE) begin
          total_nxt = total_r - CW'(1);
          if (total_r > lo_r + CW'(1)) begin
            e_nxt     = lo_r + CW'(1);
            a_nxt     = base_c + HPK_F;
            state_nxt = S_SHR;
          end
        end else if (n_c != '0) begin
          cnt_nxt   = n_c;
          i_nxt     = '0;
          state_nxt = S_LURD;
        end
      end
      S_SHR: begin
        ent_re    = 1'b1;
        ent_raddr = e_r[EAW-1:0];
        state_nxt = S_SHW;
      end
      S_SHW: begin
        // move one entry up on insert, down on remove
        ent_we    = 1'b1;
        ent_wdata = ent_rd;
        if (req_r == REQ_INSERT) begin
          ent_waddr = e_up[EAW-1:0];
          if (e_r == lo_r) begin
            state_nxt = S_HSR;
          end else begin
            e_nxt     = e_dn;
            state_nxt = S_SHR;
          end
        end else begin
          ent_waddr = e_dn[EAW-1:0];
          if (e_r == total_r) begin
            state_nxt = S_HSR;
          end else begin
            e_nxt     = e_up;
            state_nxt = S_SHR;
          end
        end
      end
      S_HSR: begin
        hdl_re    = 1'b1;
        hdl_raddr = a_r[HAW-1:0];
        state_nxt = S_HSW;
      end
      S_HSW: begin
        // move one handle slot by a whole row
        hdl_we    = 1'b1;
        hdl_wdata = hdl_rd;
        if (req_r == REQ_INSERT) begin
          hdl_waddr = a_up[HAW-1:0];
          if (a_r == base_r) begin
            state_nxt = S_FIN;
          end else begin
            a_nxt     = a_r - HFW'(1);
            state_nxt = S_HSR;
          end
        end else begin
          hdl_waddr = a_dn[HAW-1:0];
          if (a_r == end_r - HFW'(1)) begin
            state_nxt = S_RESP;
          end else begin
            a_nxt     = a_r + HFW'(1);
            state_nxt = S_HSR;
          end
        end
      end
      S_FIN: begin
        ent_we     = 1'b1;
        hdl_we     = 1'b1;
        total_nxt  = total_r + CW'(1);
        res_nxt    = '{status: ST_OK, handle_out: '0, item_count: 4'd1, last_result: 1'b1};
        state_nxt  = S_RESP;
      end
      S_LURD: begin
        hdl_re    = 1'b1;
        hdl_raddr = lu_addr[HAW-1:0];
        state_nxt = S_LUOUT;
      end
      S_LUOUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_OK, handle_out: hdl_rd, item_count: 4'(cnt_r),
                            last_result: (i_r + HCW'(1) == cnt_r)};
          if (i_r + HCW'(1) == cnt_r) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + HCW'(1);
            state_nxt = S_LURD;
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= HASH_SEED;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    fold_r     <= fold_nxt;
    h_r        <= h_nxt;
    req_r      <= req_nxt;
    hdl_r      <= hdl_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    e_r        <= e_nxt;
    a_r        <= a_nxt;
    base_r     <= base_nxt;
    end_r      <= end_nxt;
    cnt_r      <= cnt_nxt;
    i_r        <= i_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  `HKST_ASSERT_SAME(a_total_range, 1'b1, total_r <= TD_C, "entry count beyond table depth")
  `HKST_ASSERT_NEXT(a_last_starts, in_acc && in_data.key_last, state_r == S_FOLD, "key end did not start the hash reduction")
  `HKST_ASSERT_SAME(a_lookup_idx, state_r == S_LUOUT, i_r < cnt_r && cnt_r != '0, "lookup slot index out of range")
  `HKST_ASSERT_NEXT(a_no_overwrite, out_valid_r && out_stall, out_valid_r && $stable(out_data_r), "pending result overwritten")

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import hkst_pkg::*;

  localparam int DEPTH = 64;
  localparam int SLOTS = 8;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  hashed_key_sorted_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor state: sorted table of key hashes with handle lists
  logic [63:0] acc_q = HASH_SEED;
  int unsigned n_entries = 0;
  logic [30:0] hash_tbl [DEPTH];
  int unsigned cnt_tbl [DEPTH];
  logic [31:0] hdl_tbl [DEPTH][SLOTS];
  out_t expected_q[$];
  int errors = 0;
  int unsigned pct_idle = 0;
  int unsigned pct_stall = 0;
  int unsigned cycles = 0;

  function automatic out_t mk(status_t s, logic [31:0] h, int unsigned c, bit l);
    out_t r;
    r.status = s;
    r.handle_out = h;
    r.item_count = c[3:0];
    r.last_result = l;
    return r;
  endfunction

  // fold one accepted byte, run the operation on the last one
  task automatic predict_table(in_t t);
    logic [30:0] h;
    int unsigned pos;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned n;
    bit hit;
    acc_q = (acc_q << 5) + acc_q + 64'(t.key_byte);
    if (!t.key_last) return;
    h = 31'(acc_q % 64'(HASH_MOD));
    acc_q = HASH_SEED;
    lo = 0;
    hi = n_entries;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (hash_tbl[mid] < h) lo = mid + 1;
      else hi = mid;
    end
    pos = lo;
    hit = (pos < n_entries) && (hash_tbl[pos] == h);
    if (t.req_type == REQ_INSERT) begin
      if (hit) begin
        n = cnt_tbl[pos];
        if (n >= SLOTS) expected_q.push_back(mk(ST_LIST_FULL, 0, n, 1));
        else begin
          hdl_tbl[pos][n] = t.data_handle;
          cnt_tbl[pos] = n + 1;
          expected_q.push_back(mk(ST_OK, 0, n + 1, 1));
        end
      end else if (n_entries >= DEPTH) begin
        expected_q.push_back(mk(ST_TBL_FULL, 0, 0, 1));
      end else begin
        for (int i = n_entries; i > pos; i--) begin
          hash_tbl[i] = hash_tbl[i-1];
          cnt_tbl[i] = cnt_tbl[i-1];
          hdl_tbl[i] = hdl_tbl[i-1];
        end
        hash_tbl[pos] = h;
        cnt_tbl[pos] = 1;
        hdl_tbl[pos][0] = t.data_handle;
        n_entries++;
        expected_q.push_back(mk(ST_OK, 0, 1, 1));
      end
    end else if (!hit) begin
      expected_q.push_back(mk(ST_NOT_FOUND, 0, 0, 1));
    end else if (t.req_type == REQ_REMOVE) begin
      for (int i = pos; i + 1 < n_entries; i++) begin
        hash_tbl[i] = hash_tbl[i+1];
        cnt_tbl[i] = cnt_tbl[i+1];
        hdl_tbl[i] = hdl_tbl[i+1];
      end
      n_entries--;
      expected_q.push_back(mk(ST_OK, 0, 0, 1));
    end else begin
      n = cnt_tbl[pos];
      for (int i = 0; i < n; i++)
        expected_q.push_back(mk(ST_OK, hdl_tbl[pos][i], n, i + 1 == n));
    end
  endtask

  // send one transaction, return once accepted; valid stays up for the next one
  task automatic send_byte(in_t t);
    if (pct_idle != 0 && $urandom_range(99) < pct_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < pct_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    predict_table(t);
  endtask

  // drop valid and hold until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (expected_q.size() == 0);
  endtask

  // one key: string of bytes ending with the operation
  task automatic send_key(req_t op, logic [7:0] k0, int unsigned len, logic [31:0] hdl);
    in_t t;
    for (int i = 0; i < len; i++) begin
      t.req_type = (i + 1 == len) ? op : req_t'($urandom_range(3));
      t.key_byte = (i == 0) ? k0 : 8'($urandom_range(1, 255));
      t.key_last = (i + 1 == len);
      t.data_handle = (i + 1 == len) ? hdl : $urandom;
      send_byte(t);
    end
  endtask

  // receiver side: random stall, compare against the oldest expectation
  always @(posedge clk) begin
    out_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result %h", out_data);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_data.status); errors++;
          end
          if (out_data.handle_out !== e.handle_out) begin
            $error("handle_out exp %h got %h", e.handle_out, out_data.handle_out);
            errors++;
          end
          if (out_data.item_count !== e.item_count) begin
            $error("item_count exp %0d got %0d", e.item_count, out_data.item_count);
            errors++;
          end
          if (out_data.last_result !== e.last_result) begin
            $error("last_result exp %0d got %0d", e.last_result, out_data.last_result);
            errors++;
          end
        end
      end
      out_stall <= (pct_stall != 0) && ($urandom_range(99) < pct_stall);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // directed rows: op, first byte, length, handle, typed status and count
  typedef struct {
    req_t op;
    logic [7:0] k0;
    int unsigned len;
    logic [31:0] hdl;
    bit has_exp;
    status_t exp_st;
    logic [3:0] exp_cnt;
  } row_t;

  initial begin
    row_t rows [$];
    in_t t;
    out_t last_e;
    int unsigned phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: absent keys, extremes, list full, spare op, remove
    rows.push_back('{REQ_LOOKUP, 8'd1, 1, 32'h0, 1'b1, ST_NOT_FOUND, 4'd0});
    rows.push_back('{REQ_REMOVE, 8'd255, 1, 32'h0, 1'b1, ST_NOT_FOUND, 4'd0});
    rows.push_back('{REQ_INSERT, 8'd1, 1, 32'h0, 1'b1, ST_OK, 4'd1});
    rows.push_back('{REQ_INSERT, 8'd255, 1, 32'hFFFF_FFFF, 1'b1, ST_OK, 4'd1});
    for (int i = 0; i < 7; i++)
      rows.push_back('{REQ_INSERT, 8'd1, 1, 32'hA5A5_0000 + i, 1'b1, ST_OK, 4'(i + 2)});
    rows.push_back('{REQ_INSERT, 8'd1, 1, 32'hA5A5_0007, 1'b1, ST_LIST_FULL, 4'd8});
    rows.push_back('{REQ_LOOKUP, 8'd1, 1, 32'h0, 1'b0, ST_OK, 4'd0});
    rows.push_back('{REQ_SPARE, 8'd255, 1, 32'h0, 1'b0, ST_OK, 4'd0});
    rows.push_back('{REQ_REMOVE, 8'd1, 1, 32'h0, 1'b1, ST_OK, 4'd0});
    rows.push_back('{REQ_LOOKUP, 8'd1, 1, 32'h0, 1'b1, ST_NOT_FOUND, 4'd0});
    rows.push_back('{REQ_INSERT, 8'h80, 1, 32'h5555_AAAA, 1'b0, ST_OK, 4'd0});
    rows.push_back('{REQ_LOOKUP, 8'h80, 1, 32'h0, 1'b0, ST_OK, 4'd0});
    foreach (rows[i]) begin
      t.req_type = rows[i].op;
      t.key_byte = rows[i].k0;
      t.key_last = 1'b1;
      t.data_handle = rows[i].hdl;
      send_byte(t);
      if (rows[i].has_exp) begin
        last_e = expected_q[$];
        if (last_e.status !== rows[i].exp_st) begin
          $error("status exp %0d got %0d", rows[i].exp_st, last_e.status); errors++;
        end
        if (last_e.item_count !== rows[i].exp_cnt) begin
          $error("item_count exp %0d got %0d", rows[i].exp_cnt, last_e.item_count);
          errors++;
        end
      end
    end
    // a multi-byte key with every bit of the byte set somewhere
    t = '{REQ_INSERT, 8'hFF, 1'b0, 32'h0}; send_byte(t);
    t = '{REQ_INSERT, 8'h7F, 1'b1, 32'h1234_5678}; send_byte(t);

    // fill the table to get the table-full status, then remove random keys and drain
    for (int i = 0; i < 70; i++) send_key(REQ_INSERT, 8'(i + 2), 1, $urandom);
    for (int i = 0; i < 70; i++) send_key(REQ_REMOVE, 8'($urandom_range(2, 80)), 1, 0);
    drain();
    repeat (300) @(posedge clk);

    // random traffic over a small key space, in idling and stalling phases
    for (int i = 0; i < 80; i++) begin
      phase = i / 20;
      case (phase)
        0: begin pct_idle = 0; pct_stall = 0; end
        1: begin pct_idle = 85; pct_stall = 0; end
        2: begin pct_idle = 0; pct_stall = 85; end
        3: begin pct_idle = 35; pct_stall = 35; end
        default: begin pct_idle = 0; pct_stall = 0; end
      endcase
      if ($urandom_range(9) == 0) begin
        send_key(req_t'($urandom_range(3)), 8'($urandom_range(1, 255)),
                 $urandom_range(1, 4), $urandom);
      end else begin
        send_key(req_t'($urandom_range(2) == 0 ? 0 : $urandom_range(2)),
                 8'($urandom_range(1, 12)), 1, $urandom);
      end
      if (i == 40) drain();
    end
    pct_idle = 0;
    pct_stall = 0;

    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end
endmodule
